FILE: src/lfts_pkg.sv
// ----------------------------------------------------------------------------
// lfts_pkg
// Shared types, codes and arithmetic for the LED frame smoother.
// ----------------------------------------------------------------------------
package lfts_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT     = 1'd1;

  localparam logic [23:0] IDLE_TIMEOUT_RESET = 24'd500000;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_PIXEL = 2'd1;
  localparam kind_t KIND_BLANK = 2'd2;

  typedef logic [23:0] rgb_t;

  // floor(x / 10) for x below 2560: multiply by 3277 / 2^15
  function automatic logic [7:0] div10(input logic [11:0] x);
    logic [23:0] prod;
    prod = {12'd0, x} * 24'd3277;
    return prod[22:15];
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] cur, input logic [7:0] old,
                                       input logic [7:0] prev, input logic [7:0] nxt);
    logic [8:0]  sum2;
    logic [7:0]  avg;
    logic [11:0] acc;
    sum2 = {1'b0, cur} + {1'b0, old};
    avg  = sum2[8:1];
    acc  = 12'd3 * {4'd0, prev} + {2'd0, avg, 2'b00} + 12'd3 * {4'd0, nxt};
    return div10(acc);
  endfunction

endpackage

FILE: src/led_frame_temporal_spatial_smoother.sv
// ----------------------------------------------------------------------------
// led_frame_temporal_spatial_smoother
// Temporal and spatial smoothing of a ring LED frame, pixel store in one RAM.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes the second-stage and output registers.
// Throughput: one transaction per cycle while out_stall is low; the RAM reads
// the next neighbor at accept and writes the blended pixel back from stage 2.
// Reset: control clears at once; the pixel RAM is not swept, a frame-fresh
// flag makes unwritten entries read as black after reset and after blanking.
// ----------------------------------------------------------------------------
module led_frame_temporal_spatial_smoother
  import lfts_pkg::*;
#(
  parameter int LED_COUNT = 188
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            pixel_index,
  output logic [7:0]            red_out,
  output logic [7:0]            green_out,
  output logic [7:0]            blue_out,
  output logic                  frame_end,
  output logic                  blank_all
);

  localparam int POS_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LED_COUNT - 1);

  rgb_t mem [LED_COUNT];

  logic             smoothing_enable;
  logic [23:0]      idle_timeout;
  logic [23:0]      idle_count;
  logic             blanked;
  logic             fresh;
  logic [POS_W-1:0] position;

  logic [POS_W-1:0] rd_addr;
  logic             rd_en;
  rgb_t             rd_data;
  logic             rd_zero;

  logic             s2_valid;
  kind_t            s2_kind;
  logic [POS_W-1:0] s2_pos;
  rgb_t             s2_in;

  rgb_t             old_hold;
  rgb_t             previous_written;
  rgb_t             first_written;

  logic             in_acc;
  logic             out_free;
  logic             s2_go;
  logic             is_last;
  rgb_t             nxt_raw;
  rgb_t             nxt;
  rgb_t             colour;
  logic [POS_W+7:0] pos_wide;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s2_valid && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign s2_go    = s2_valid && out_free;

  assign is_last = (position == LAST_POS);
  assign rd_addr = is_last ? '0 : position + POS_W'(1);
  assign rd_en   = in_acc && (req_type == REQ_PIXEL);

  assign nxt_raw = rd_zero ? '0 : rd_data;
  assign nxt     = (s2_pos == LAST_POS) ? first_written : nxt_raw;

  always_comb begin
    if (smoothing_enable) begin
      colour = {blend(s2_in[23:16], old_hold[23:16], previous_written[23:16], nxt[23:16]),
                blend(s2_in[15:8],  old_hold[15:8],  previous_written[15:8],  nxt[15:8]),
                blend(s2_in[7:0],   old_hold[7:0],   previous_written[7:0],   nxt[7:0])};
    end else begin
      colour = s2_in;
    end
  end

  assign pos_wide = {8'd0, s2_pos};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_enable <= 1'b1;
      idle_timeout     <= IDLE_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMOOTHING_ENABLE: smoothing_enable <= cfg_data[0];
        REG_IDLE_TIMEOUT:     idle_timeout     <= cfg_data;
        default: ;
      endcase
    end
  end

  // RAM
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (s2_go && s2_kind == KIND_PIXEL) begin
      mem[s2_pos] <= colour;
    end
  end

  // accept stage: sequencing decisions
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= '0;
      blanked    <= 1'b0;
      fresh      <= 1'b1;
      position   <= '0;
      rd_zero    <= 1'b1;
      s2_valid   <= 1'b0;
      s2_kind    <= KIND_NONE;
    end else begin
      if (in_acc) begin
        s2_valid <= 1'b1;
        s2_pos   <= position;
        s2_in    <= {red_in, green_in, blue_in};
        if (req_type == REQ_PIXEL) begin
          s2_kind    <= KIND_PIXEL;
          idle_count <= '0;
          blanked    <= 1'b0;
          rd_zero    <= fresh && !is_last;
          position   <= rd_addr;
          if (is_last) begin
            fresh <= 1'b0;
          end
        end else if (blanked) begin
          s2_kind <= KIND_NONE;
        end else if (idle_count >= idle_timeout) begin
          s2_kind  <= KIND_BLANK;
          blanked  <= 1'b1;
          fresh    <= 1'b1;
          position <= '0;
        end else begin
          s2_kind    <= KIND_NONE;
          idle_count <= idle_count + 24'd1;
        end
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // blend stage: write back and neighbor tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      old_hold         <= '0;
      previous_written <= '0;
      first_written    <= '0;
    end else if (s2_go) begin
      unique case (s2_kind)
        KIND_PIXEL: begin
          old_hold         <= nxt_raw;
          previous_written <= colour;
          if (s2_pos == '0) begin
            first_written <= colour;
          end
        end
        KIND_BLANK: begin
          old_hold         <= '0;
          previous_written <= '0;
          first_written    <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s2_kind != KIND_NONE) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_kind != KIND_NONE) begin
      if (s2_kind == KIND_PIXEL) begin
        pixel_index <= pos_wide[7:0];
        red_out     <= colour[23:16];
        green_out   <= colour[15:8];
        blue_out    <= colour[7:0];
        frame_end   <= (s2_pos == LAST_POS);
        blank_all   <= 1'b0;
      end else begin
        pixel_index <= '0;
        red_out     <= '0;
        green_out   <= '0;
        blue_out    <= '0;
        frame_end   <= 1'b0;
        blank_all   <= 1'b1;
      end
    end
  end

endmodule
